// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files of the gradient magnitude block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VGM_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define VGM_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("assertion failed");
`else
`define VGM_ASSERT(label, clk, rst_n, prop)
`define VGM_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ----- rtl/core/vgm_pkg.sv -----
// Shared types and constants of the gradient magnitude block.
`default_nettype none
package vgm_pkg;
	localparam int SAMPLE_W = 17;
	localparam int SIZE_W   = 9;
	localparam int INV_W    = 16;
	localparam int MAG_W    = 33;
	localparam int GRAD_W   = 34;
	localparam int HALF_W   = 17;
	localparam int PROD_W   = 34;
	localparam int ACC_W    = 70;
	localparam int IDX_W    = 3;
	localparam int SQ_STEPS = 33;

	localparam logic [IDX_W-1:0] REG_SIZE_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_SIZE_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_SIZE_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_INV_X  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INV_Y  = 3'd4;
	localparam logic [IDX_W-1:0] REG_INV_Z  = 3'd5;

	typedef enum logic [2:0] {MUL_NONE, MUL_DI, MUL_LL, MUL_HL, MUL_HH} mul_op_t;
	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	typedef struct packed {
		logic    accept;
		logic    clr;
		logic    rd;
		logic    rd_fwd;
		logic    cap_s1;
		logic    cap_s0;
		logic    diff;
		mul_op_t mop;
		axis_t   axis;
		logic    sq_init;
		logic    sq_step;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic clr_last;
		logic size_wr;
		logic out_busy;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/vgm_stream_if.sv -----
// Valid/ready channel interfaces for voxel input and magnitude output.
`default_nettype none
interface vgm_vox_if;
	logic valid;
	logic ready;
	logic func;
	logic signed [vgm_pkg::SAMPLE_W-1:0] sample;
	modport source (output valid, func, sample, input ready);
	modport sink (input valid, func, sample, output ready);
endinterface

interface vgm_res_if;
	logic valid;
	logic ready;
	logic [vgm_pkg::MAG_W-1:0] magnitude;
	logic last;
	modport source (output valid, magnitude, last, input ready);
	modport sink (input valid, magnitude, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/volume_gradient_magnitude_top.sv -----
// Top level of the streaming 3-D gradient magnitude block.
// Usage:
//   vox channel: voxels in raster order (x fastest), func 0 = sample, func 1 = drain.
//   res channel: magnitude (8 fraction bits, saturated) and last for the final voxel.
//   wr_en/wr_index/wr_data: size_x, size_y, size_z, inv_spacing_x/y/z (Q8.8), idle only.
// Latency: a voxel's result leaves after size_x*size_y + size_x + 1 further voxels;
//   drain items flush the pending results after the last voxel.
// Pacing: a transaction without a result leaves the block idle; one with a result holds
//   off the next until done, paced by the single window read port (six reads), the shared
//   17x17 multiplier (four products per axis) and the 33-step bit-serial square root.
// Reset: the window memory is cleared one entry a cycle, all 2*MAX_X*MAX_Y + MAX_X + 1
//   entries, then ST_SETUP lets the plane and lag settle before vox.ready rises.
// Size writes hold vox.ready low in ST_SETUP while the plane and lag settle.
// Stall: a finished result waits in the output register; the next transaction is taken
//   while it waits, and the block holds only when a new result finds the register full.
`default_nettype none
module volume_gradient_magnitude_top #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	vgm_vox_if.sink                            vox,
	vgm_res_if.source                          res,
	input  wire logic                          wr_en,
	input  wire logic [vgm_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [vgm_pkg::INV_W-1:0]     wr_data
);
	vgm_pkg::dp_cmd_t  cmd;
	vgm_pkg::dp_stat_t stat;
	logic vox_ready;
	logic res_valid;
	logic [vgm_pkg::MAG_W-1:0] res_magnitude;
	logic res_last;

	vgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vox.valid),
		.in_ready (vox_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vgm_dp #(
		.MAX_X (MAX_X),
		.MAX_Y (MAX_Y),
		.MAX_Z (MAX_Z)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.vox_func      (vox.func),
		.vox_sample    (vox.sample),
		.res_ready     (res.ready),
		.res_valid     (res_valid),
		.res_magnitude (res_magnitude),
		.res_last      (res_last),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	assign vox.ready = vox_ready;
	assign res.valid = res_valid;
	assign res.magnitude = res_magnitude;
	assign res.last = res_last;
endmodule
`default_nettype wire

// ----- rtl/core/vgm_ctrl.sv -----
// Controller state machine sequencing reads, multiplies and the square root.
`default_nettype none
module vgm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire vgm_pkg::dp_stat_t stat,
	output vgm_pkg::dp_cmd_t      cmd
);
	typedef enum logic [2:0] {ST_CLEAR, ST_SETUP, ST_IDLE, ST_AXIS, ST_SQ_INIT, ST_SQ_RUN,
		ST_OUT} state_t;

	localparam logic [3:0] STEP_RD_F = 4'd0;
	localparam logic [3:0] STEP_RD_B = 4'd1;
	localparam logic [3:0] STEP_CAP  = 4'd2;
	localparam logic [3:0] STEP_DIFF = 4'd3;
	localparam logic [3:0] STEP_DI   = 4'd4;
	localparam logic [3:0] STEP_LL   = 4'd6;
	localparam logic [3:0] STEP_HL   = 4'd7;
	localparam logic [3:0] STEP_HH   = 4'd8;
	localparam logic [3:0] STEP_LAST = 4'd9;
	localparam logic [5:0] SQ_LAST   = 6'(vgm_pkg::SQ_STEPS - 1);

	state_t         state_q;
	logic [3:0]     step_q;
	vgm_pkg::axis_t axis_q;
	logic [5:0]     sq_cnt_q;
	logic           setup_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.mop = vgm_pkg::MUL_NONE;
		cmd.axis = axis_q;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: cmd.accept = in_valid;
			ST_AXIS: begin
				case (step_q)
					STEP_RD_F: begin
						cmd.rd = 1'b1;
						cmd.rd_fwd = 1'b1;
					end
					STEP_RD_B: begin
						cmd.rd = 1'b1;
						cmd.cap_s1 = 1'b1;
					end
					STEP_CAP: cmd.cap_s0 = 1'b1;
					STEP_DIFF: cmd.diff = 1'b1;
					STEP_DI: cmd.mop = vgm_pkg::MUL_DI;
					STEP_LL: cmd.mop = vgm_pkg::MUL_LL;
					STEP_HL: cmd.mop = vgm_pkg::MUL_HL;
					STEP_HH: cmd.mop = vgm_pkg::MUL_HH;
					default: cmd.mop = vgm_pkg::MUL_NONE;
				endcase
			end
			ST_SQ_INIT: cmd.sq_init = 1'b1;
			ST_SQ_RUN: cmd.sq_step = 1'b1;
			ST_OUT: cmd.out_load = !stat.out_busy;
			default: cmd.clr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q <= '0;
			axis_q <= vgm_pkg::AX_X;
			sq_cnt_q <= '0;
			setup_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (stat.clr_last) begin
						state_q <= ST_SETUP;
						setup_q <= 1'b0;
					end
				end
				ST_SETUP: begin
					// hold until the derived plane and lag registers settle
					if (stat.size_wr) setup_q <= 1'b0;
					else if (setup_q) state_q <= ST_IDLE;
					else setup_q <= 1'b1;
				end
				ST_IDLE: begin
					if (stat.size_wr) begin
						state_q <= ST_SETUP;
						setup_q <= 1'b0;
					end else if (in_valid && stat.emit) begin
						state_q <= ST_AXIS;
						step_q <= STEP_RD_F;
						axis_q <= vgm_pkg::AX_X;
					end
				end
				ST_AXIS: begin
					if (step_q == STEP_LAST) begin
						step_q <= STEP_RD_F;
						case (axis_q)
							vgm_pkg::AX_X: axis_q <= vgm_pkg::AX_Y;
							vgm_pkg::AX_Y: axis_q <= vgm_pkg::AX_Z;
							default: state_q <= ST_SQ_INIT;
						endcase
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_SQ_INIT: begin
					state_q <= ST_SQ_RUN;
					sq_cnt_q <= '0;
				end
				ST_SQ_RUN: begin
					if (sq_cnt_q == SQ_LAST) state_q <= ST_OUT;
					else sq_cnt_q <= sq_cnt_q + 6'd1;
				end
				ST_OUT: begin
					if (!stat.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/vgm_dp.sv -----
// Datapath: window memory, positions, shared multiplier, accumulator and square root.
`default_nettype none
`include "assert_macros.svh"
module vgm_dp #(
	parameter int MAX_X = 256,
	parameter int MAX_Y = 256,
	parameter int MAX_Z = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire vgm_pkg::dp_cmd_t                      cmd,
	output vgm_pkg::dp_stat_t                          stat,
	input  wire logic                                  vox_func,
	input  wire logic signed [vgm_pkg::SAMPLE_W-1:0]   vox_sample,
	input  wire logic                                  res_ready,
	output logic                                       res_valid,
	output logic [vgm_pkg::MAG_W-1:0]                  res_magnitude,
	output logic                                       res_last,
	input  wire logic                                  wr_en,
	input  wire logic [vgm_pkg::IDX_W-1:0]             wr_index,
	input  wire logic [vgm_pkg::INV_W-1:0]             wr_data
);
	localparam int WIN = 2 * MAX_X * MAX_Y + MAX_X + 1;
	localparam int AW = $clog2(WIN);
	localparam int CAP_X = (MAX_X < 511) ? MAX_X : 511;
	localparam int CAP_Y = (MAX_Y < 511) ? MAX_Y : 511;
	localparam int CAP_Z = (MAX_Z < 511) ? MAX_Z : 511;
	localparam int RST_X = (MAX_X < 256) ? MAX_X : 256;
	localparam int RST_Y = (MAX_Y < 256) ? MAX_Y : 256;
	localparam int RST_Z = (MAX_Z < 256) ? MAX_Z : 256;
	localparam int SW = vgm_pkg::SIZE_W;
	localparam int HW = vgm_pkg::HALF_W;

	function automatic logic [SW-1:0] clamp_size(logic [SW-1:0] v, logic [SW-1:0] cap);
		logic [SW-1:0] r;
		r = v;
		if (v == '0) r = SW'(1);
		else if (v > cap) r = cap;
		return r;
	endfunction

	// configuration and derived geometry
	logic [SW-1:0] sx_q, sy_q, sz_q;
	logic [vgm_pkg::INV_W-1:0] inv_x_q, inv_y_q, inv_z_q;
	logic [AW-1:0] plane_q, lag_q;

	// stream positions
	logic [AW-1:0] ip_q, pend_q, clr_q, slot_q;
	logic [SW-1:0] ox_q, oy_q, oz_q, cx_q, cy_q, cz_q;
	logic          clast_q;

	// window memory
	logic signed [vgm_pkg::SAMPLE_W-1:0] mem [WIN];
	logic signed [vgm_pkg::SAMPLE_W-1:0] rd_q, s1_q, s0_q;
	logic [vgm_pkg::SAMPLE_W-1:0] dabs_q;
	logic                                defer_q;
	logic [AW-1:0]                       dw_addr_q;
	logic signed [vgm_pkg::SAMPLE_W-1:0] dw_data_q;

	// arithmetic
	logic [vgm_pkg::PROD_W-1:0] prod_s1;
	vgm_pkg::mul_op_t           ptag_s1;
	logic                       edge_s1;
	logic [vgm_pkg::GRAD_W-1:0] a_q;
	logic [vgm_pkg::ACC_W-1:0]  acc_q, rem_q, t_q, q_q;
	logic                       out_valid_q;
	logic [vgm_pkg::MAG_W-1:0]  mag_q;
	logic                       last_q;

	logic size_wr, emit, mem_we;
	logic [AW-1:0] waddr, raddr, stride, off, back_dist;
	logic signed [vgm_pkg::SAMPLE_W-1:0] wdata;
	logic [AW:0] slot_sum, fwd_sum, back_sum;
	logic [SW-1:0] coord, extent;
	logic has_f, has_b;
	logic [vgm_pkg::SAMPLE_W:0] diff, dmag;
	logic [HW-1:0] op_a, op_b;
	logic [vgm_pkg::PROD_W-1:0] mul_full;
	logic [vgm_pkg::ACC_W-1:0] trial;

	assign size_wr = wr_en && (wr_index == vgm_pkg::REG_SIZE_X ||
		wr_index == vgm_pkg::REG_SIZE_Y || wr_index == vgm_pkg::REG_SIZE_Z);
	assign emit = vox_func ? (pend_q != '0) : (pend_q >= lag_q);

	assign stat.emit = emit;
	assign stat.clr_last = (clr_q == AW'(WIN - 1));
	assign stat.size_wr = size_wr;
	assign stat.out_busy = out_valid_q && !res_ready;

	// slot of the voxel whose result goes out now
	assign back_dist = vox_func ? pend_q : lag_q;
	assign slot_sum = {1'b0, ip_q} + (AW+1)'(WIN) - {1'b0, back_dist};

	always_comb begin
		case (cmd.axis)
			vgm_pkg::AX_X: begin
				stride = AW'(1);
				coord = cx_q;
				extent = sx_q;
			end
			vgm_pkg::AX_Y: begin
				stride = AW'(sx_q);
				coord = cy_q;
				extent = sy_q;
			end
			default: begin
				stride = plane_q;
				coord = cz_q;
				extent = sz_q;
			end
		endcase
	end

	assign has_f = (coord != extent - SW'(1));
	assign has_b = (coord != '0);
	assign off = (cmd.rd_fwd ? has_f : has_b) ? stride : '0;
	assign fwd_sum = {1'b0, slot_q} + {1'b0, off};
	assign back_sum = {1'b0, slot_q} + (AW+1)'(WIN) - {1'b0, off};

	always_comb begin
		if (cmd.rd_fwd) raddr = (fwd_sum >= (AW+1)'(WIN)) ? AW'(fwd_sum - (AW+1)'(WIN))
			: AW'(fwd_sum);
		else raddr = (back_sum >= (AW+1)'(WIN)) ? AW'(back_sum - (AW+1)'(WIN))
			: AW'(back_sum);
	end

	// a sample that pushes out a result is written after the neighbor reads:
	// at full volume size its slot still holds the back z neighbor
	assign mem_we = cmd.clr || (cmd.accept && !vox_func && !emit) || (cmd.sq_init && defer_q);
	assign waddr = cmd.clr ? clr_q : (cmd.sq_init ? dw_addr_q : ip_q);
	assign wdata = cmd.clr ? '0 : (cmd.sq_init ? dw_data_q : vox_sample);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (cmd.rd) rd_q <= mem[raddr];
	end

	assign diff = {s1_q[vgm_pkg::SAMPLE_W-1], s1_q} - {s0_q[vgm_pkg::SAMPLE_W-1], s0_q};
	assign dmag = diff[vgm_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;

	always_comb begin
		case (cmd.mop)
			vgm_pkg::MUL_DI: begin
				op_a = dabs_q;
				case (cmd.axis)
					vgm_pkg::AX_X: op_b = HW'(inv_x_q);
					vgm_pkg::AX_Y: op_b = HW'(inv_y_q);
					default: op_b = HW'(inv_z_q);
				endcase
			end
			vgm_pkg::MUL_LL: begin
				op_a = a_q[HW-1:0];
				op_b = a_q[HW-1:0];
			end
			vgm_pkg::MUL_HL: begin
				op_a = a_q[2*HW-1:HW];
				op_b = a_q[HW-1:0];
			end
			vgm_pkg::MUL_HH: begin
				op_a = a_q[2*HW-1:HW];
				op_b = a_q[2*HW-1:HW];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_full = vgm_pkg::PROD_W'(op_a) * vgm_pkg::PROD_W'(op_b);
	assign trial = t_q + q_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept && emit) begin
			slot_q <= (slot_sum >= (AW+1)'(WIN)) ? AW'(slot_sum - (AW+1)'(WIN))
				: AW'(slot_sum);
			cx_q <= ox_q;
			cy_q <= oy_q;
			cz_q <= oz_q;
			clast_q <= (ox_q == sx_q - SW'(1)) && (oy_q == sy_q - SW'(1)) &&
				(oz_q == sz_q - SW'(1));
		end
		if (cmd.accept && emit && !vox_func) begin
			dw_addr_q <= ip_q;
			dw_data_q <= vox_sample;
		end
		if (cmd.cap_s1) s1_q <= rd_q;
		if (cmd.cap_s0) s0_q <= rd_q;
		if (cmd.diff) dabs_q <= dmag[vgm_pkg::SAMPLE_W-1:0];
		prod_s1 <= mul_full;
		if (cmd.mop == vgm_pkg::MUL_DI) edge_s1 <= !(has_f && has_b);
		if (ptag_s1 == vgm_pkg::MUL_DI)
			a_q <= edge_s1 ? {prod_s1[vgm_pkg::PROD_W-2:0], 1'b0} : prod_s1;
		if (cmd.accept) acc_q <= '0;
		else begin
			case (ptag_s1)
				vgm_pkg::MUL_LL: acc_q <= acc_q + vgm_pkg::ACC_W'(prod_s1);
				vgm_pkg::MUL_HL: acc_q <= acc_q + (vgm_pkg::ACC_W'(prod_s1) << HW + 1);
				vgm_pkg::MUL_HH: acc_q <= acc_q + (vgm_pkg::ACC_W'(prod_s1) << 2 * HW);
				default: acc_q <= acc_q;
			endcase
		end
		// one result bit per step: t tracks root << bit, q is 4^bit
		if (cmd.sq_init) begin
			rem_q <= acc_q >> 2;
			t_q <= '0;
			q_q <= vgm_pkg::ACC_W'(1) << 2 * (vgm_pkg::SQ_STEPS - 1);
		end else if (cmd.sq_step) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				t_q <= (t_q >> 1) + q_q;
			end else begin
				t_q <= t_q >> 1;
			end
			q_q <= q_q >> 2;
		end
		if (cmd.out_load) begin
			mag_q <= t_q[vgm_pkg::MAG_W-1:0];
			last_q <= clast_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= SW'(RST_X);
			sy_q <= SW'(RST_Y);
			sz_q <= SW'(RST_Z);
			inv_x_q <= vgm_pkg::INV_W'(256);
			inv_y_q <= vgm_pkg::INV_W'(256);
			inv_z_q <= vgm_pkg::INV_W'(256);
			plane_q <= AW'(RST_X * RST_Y);
			lag_q <= AW'(RST_X * RST_Y + RST_X + 1);
			ip_q <= '0;
			pend_q <= '0;
			clr_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			ptag_s1 <= vgm_pkg::MUL_NONE;
			out_valid_q <= 1'b0;
			defer_q <= 1'b0;
		end else begin
			plane_q <= AW'(sx_q) * AW'(sy_q);
			lag_q <= AW'(plane_q + AW'(sx_q) + AW'(1));
			ptag_s1 <= cmd.mop;
			if (cmd.clr) clr_q <= clr_q + AW'(1);
			if (cmd.accept && !vox_func && emit) defer_q <= 1'b1;
			else if (cmd.sq_init) defer_q <= 1'b0;
			if (wr_en) begin
				case (wr_index)
					vgm_pkg::REG_SIZE_X: sx_q <= clamp_size(wr_data[SW-1:0], SW'(CAP_X));
					vgm_pkg::REG_SIZE_Y: sy_q <= clamp_size(wr_data[SW-1:0], SW'(CAP_Y));
					vgm_pkg::REG_SIZE_Z: sz_q <= clamp_size(wr_data[SW-1:0], SW'(CAP_Z));
					vgm_pkg::REG_INV_X: inv_x_q <= wr_data;
					vgm_pkg::REG_INV_Y: inv_y_q <= wr_data;
					vgm_pkg::REG_INV_Z: inv_z_q <= wr_data;
					default: inv_x_q <= inv_x_q;
				endcase
			end
			if (size_wr) begin
				// restart the volume: drop pending results
				ip_q <= '0;
				pend_q <= '0;
				ox_q <= '0;
				oy_q <= '0;
				oz_q <= '0;
			end else if (cmd.accept) begin
				if (!vox_func) begin
					ip_q <= (ip_q == AW'(WIN - 1)) ? '0 : ip_q + AW'(1);
					pend_q <= emit ? lag_q : pend_q + AW'(1);
				end else if (emit) begin
					pend_q <= pend_q - AW'(1);
				end
				if (emit) begin
					if (ox_q == sx_q - SW'(1)) begin
						ox_q <= '0;
						if (oy_q == sy_q - SW'(1)) begin
							oy_q <= '0;
							oz_q <= (oz_q == sz_q - SW'(1)) ? '0 : oz_q + SW'(1);
						end else begin
							oy_q <= oy_q + SW'(1);
						end
					end else begin
						ox_q <= ox_q + SW'(1);
					end
				end
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res_magnitude = mag_q;
	assign res_last = last_q;

	`VGM_ASSERT(a_pend_le_lag, clk, arst_n, pend_q <= lag_q)
	`VGM_NEVER(a_no_result_overwrite, clk, arst_n, cmd.out_load && out_valid_q && !res_ready)
	`VGM_NEVER(a_no_read_during_clear, clk, arst_n, cmd.clr && (cmd.rd || cmd.accept))
endmodule
`default_nettype wire

// ----- dv/volume_gradient_magnitude_top_tb.sv -----
// Testbench for the streaming 3-D gradient magnitude block: directed and random volumes.
`timescale 1ns / 1ps
`default_nettype none
module volume_gradient_magnitude_top_tb;
	localparam int MAX_X = 256;
	localparam int MAX_Y = 256;
	localparam int MAX_Z = 256;
	localparam int WIN = 2 * MAX_X * MAX_Y + MAX_X + 1;
	localparam int LIMIT = 4000000;
	localparam int SETTLE = 200;
	localparam logic FN_VOXEL = 1'b0;
	localparam logic FN_DRAIN = 1'b1;

	typedef struct {
		logic [vgm_pkg::MAG_W-1:0] magnitude;
		logic                      last;
	} grad_result_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [vgm_pkg::IDX_W-1:0] wr_index;
	logic [vgm_pkg::INV_W-1:0] wr_data;

	vgm_vox_if vox();
	vgm_res_if res();

	volume_gradient_magnitude_top #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) dut (
		.clk(clk), .arst_n(arst_n), .vox(vox), .res(res),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// predictor state
	int win_mem [WIN];
	int wr_slot, rd_pos, pending;
	int sx, sy, sz, ix, iy, iz;
	grad_result_t expected_mags[$];

	int errors, cycles, hold_cnt, src_pct, snk_pct;
	int voxels_sent, drains_sent, results_seen, volumes;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("volume_gradient_magnitude_top_tb: errors");
			$finish;
		end
	end

	// receiver: long hold-off when requested, else random stalls
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= snk_pct);
		end
	end

	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			results_seen <= results_seen + 1;
			if (expected_mags.size() == 0) begin
				$error("unexpected result: magnitude %0d last %0b", res.magnitude, res.last);
				errors <= errors + 1;
			end else begin
				grad_result_t e;
				e = expected_mags.pop_front();
				if (res.magnitude !== e.magnitude) begin
					$error("magnitude: expected %0d actual %0d", e.magnitude, res.magnitude);
					errors <= errors + 1;
				end
				if (res.last !== e.last) begin
					$error("last: expected %0b actual %0b", e.last, res.last);
					errors <= errors + 1;
				end
			end
		end
	end

	function automatic int clamp_size(logic [vgm_pkg::INV_W-1:0] v, int maxv);
		int s;
		s = int'(v[vgm_pkg::SIZE_W-1:0]);
		if (s == 0) return 1;
		if (s > maxv) return maxv;
		return s;
	endfunction

	function automatic logic [71:0] axis_square(int slot, int c, int n, int stride, int inv);
		int fwd, back, d;
		longint g;
		logic [71:0] w;
		fwd = (c + 1 < n) ? stride : 0;
		back = (c > 0) ? stride : 0;
		d = win_mem[(slot + fwd) % WIN] - win_mem[(slot + WIN - back) % WIN];
		if (d < 0) d = -d;
		g = longint'(d) * longint'(inv) * ((c > 0 && c + 1 < n) ? 1 : 2);
		w = 72'(g);
		return w * w;
	endfunction

	function automatic logic [vgm_pkg::MAG_W-1:0] floor_root(logic [71:0] n);
		logic [71:0] r, c;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (72'd1 << b);
			if (c * c <= n) r = c;
		end
		return r[vgm_pkg::MAG_W-1:0];
	endfunction

	function automatic void predict_result(int slot);
		int plane, total, x, y, z;
		logic [71:0] acc;
		grad_result_t e;
		plane = sx * sy;
		total = plane * sz;
		x = rd_pos % sx;
		y = (rd_pos / sx) % sy;
		z = rd_pos / plane;
		acc = axis_square(slot, x, sx, 1, ix) + axis_square(slot, y, sy, sx, iy)
			+ axis_square(slot, z, sz, plane, iz);
		e.magnitude = floor_root(acc >> 2);
		e.last = (rd_pos + 1 == total);
		expected_mags.push_back(e);
		rd_pos = (rd_pos + 1 >= total) ? 0 : rd_pos + 1;
	endfunction

	function automatic void predict_item(logic fn, logic signed [vgm_pkg::SAMPLE_W-1:0] smp);
		int lag, s;
		if (fn == FN_VOXEL) begin
			s = smp;
			lag = sx * sy + sx + 1;
			if (pending >= lag) begin
				predict_result((wr_slot + WIN - lag) % WIN);
				pending = lag;
			end else begin
				pending++;
			end
			win_mem[wr_slot] = s;
			wr_slot = (wr_slot + 1) % WIN;
		end else if (pending > 0) begin
			predict_result((wr_slot + WIN - pending) % WIN);
			pending--;
		end
	endfunction

	task automatic send_item(logic fn, logic signed [vgm_pkg::SAMPLE_W-1:0] smp);
		vox.valid <= 1'b1;
		vox.func <= fn;
		vox.sample <= smp;
		do @(posedge clk); while (!vox.ready);
		predict_item(fn, smp);
		if (fn == FN_VOXEL) voxels_sent++;
		else drains_sent++;
		if ($urandom_range(99) < src_pct) begin
			vox.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_rand_voxel();
		logic [31:0] r;
		r = $urandom;
		// mostly small values so gradients stay readable, sometimes full range
		if ($urandom_range(3) == 0) send_item(FN_VOXEL, r[vgm_pkg::SAMPLE_W-1:0]);
		else send_item(FN_VOXEL, vgm_pkg::SAMPLE_W'($signed(r[9:0])));
	endtask

	// flush pending results, plus one drain with nothing pending
	task automatic drain_all();
		while (pending > 0) send_item(FN_DRAIN, '0);
		send_item(FN_DRAIN, vgm_pkg::SAMPLE_W'($urandom));
	endtask

	task automatic settle();
		vox.valid <= 1'b0;
		while (expected_mags.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [vgm_pkg::IDX_W-1:0] idx, logic [vgm_pkg::INV_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			vgm_pkg::REG_SIZE_X: sx = clamp_size(val, MAX_X);
			vgm_pkg::REG_SIZE_Y: sy = clamp_size(val, MAX_Y);
			vgm_pkg::REG_SIZE_Z: sz = clamp_size(val, MAX_Z);
			vgm_pkg::REG_INV_X:  ix = val;
			vgm_pkg::REG_INV_Y:  iy = val;
			vgm_pkg::REG_INV_Z:  iz = val;
			default: ;
		endcase
		if (idx == vgm_pkg::REG_SIZE_X || idx == vgm_pkg::REG_SIZE_Y ||
			idx == vgm_pkg::REG_SIZE_Z) begin
			wr_slot = 0;
			rd_pos = 0;
			pending = 0;
		end
	endtask

	task automatic setup_volume(int x, int y, int z, int vx, int vy, int vz);
		settle();
		write_reg(vgm_pkg::REG_SIZE_X, vgm_pkg::INV_W'(x));
		write_reg(vgm_pkg::REG_SIZE_Y, vgm_pkg::INV_W'(y));
		write_reg(vgm_pkg::REG_SIZE_Z, vgm_pkg::INV_W'(z));
		write_reg(vgm_pkg::REG_INV_X, vgm_pkg::INV_W'(vx));
		write_reg(vgm_pkg::REG_INV_Y, vgm_pkg::INV_W'(vy));
		write_reg(vgm_pkg::REG_INV_Z, vgm_pkg::INV_W'(vz));
		volumes++;
	endtask

	task automatic test_extremes();
		setup_volume(3, 2, 2, 65535, 65535, 65535);
		for (int i = 0; i < 12; i++)
			send_item(FN_VOXEL, (i % 2) ? 17'sd65535 : -17'sd65536);
		drain_all();
		setup_volume(3, 3, 2, 0, 1, 128);
		for (int i = 0; i < 6; i++) send_rand_voxel();
		// drain before the neighbors arrive, then keep streaming
		send_item(FN_DRAIN, '0);
		for (int i = 0; i < 6; i++) send_rand_voxel();
		drain_all();
	endtask

	task automatic test_size_clamp();
		setup_volume(0, 1, 1, 256, 256, 256);
		send_item(FN_VOXEL, 17'sd100);
		send_item(FN_VOXEL, -17'sd5);
		drain_all();
		// oversize row acts as the maximum width
		setup_volume(511, 1, 1, 300, 256, 256);
		for (int i = 0; i < MAX_X + 4; i++) send_rand_voxel();
		drain_all();
		setup_volume(1, 1, 300, 256, 256, 65535);
		for (int i = 0; i < MAX_Z + 10; i++) send_rand_voxel();
		drain_all();
		setup_volume(1, 256, 1, 256, 700, 256);
		for (int i = 0; i < MAX_Y / 4; i++) send_rand_voxel();
		drain_all();
	endtask

	task automatic test_back_to_back();
		setup_volume(4, 3, 2, 256, 512, 1000);
		for (int i = 0; i < 3 * 24; i++) send_rand_voxel();
		drain_all();
	endtask

	task automatic test_pressure();
		setup_volume(2, 2, 1, 256, 256, 256);
		src_pct = 0;
		snk_pct = 0;
		hold_cnt = 4000;
		for (int i = 0; i < 80; i++) send_rand_voxel();
		drain_all();
	endtask

	task automatic test_random();
		int x, y, z;
		while (voxels_sent + drains_sent < 1900) begin
			case (volumes % 4)
				0: begin src_pct = 0; snk_pct = 0; end
				1: begin src_pct = 54; snk_pct = 0; end
				2: begin src_pct = 0; snk_pct = 54; end
				default: begin src_pct = 6; snk_pct = 6; end
			endcase
			x = $urandom_range(1, 6);
			y = $urandom_range(1, 5);
			z = $urandom_range(1, 4);
			if ($urandom_range(7) == 0) settle();
			else setup_volume(x, y, z, $urandom_range(0, 65535), $urandom_range(1, 1024),
				$urandom_range(1, 600));
			repeat ($urandom_range(1, 2) * sx * sy * sz) begin
				send_rand_voxel();
				if ($urandom_range(39) == 0) send_item(FN_DRAIN, '0);
			end
			if ($urandom_range(3) != 0) drain_all();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		vox.valid = 1'b0;
		vox.func = FN_VOXEL;
		vox.sample = '0;
		res.ready = 1'b0;
		errors = 0;
		cycles = 0;
		hold_cnt = 0;
		src_pct = 0;
		snk_pct = 0;
		voxels_sent = 0;
		drains_sent = 0;
		results_seen = 0;
		volumes = 0;
		foreach (win_mem[i]) win_mem[i] = 0;
		wr_slot = 0;
		rd_pos = 0;
		pending = 0;
		sx = MAX_X;
		sy = MAX_Y;
		sz = MAX_Z;
		ix = 256;
		iy = 256;
		iz = 256;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_extremes();
		test_size_clamp();
		test_back_to_back();
		test_pressure();
		test_random();

		settle();
		$display("covered %0d volumes, %0d voxels and %0d drains; %0d magnitudes checked",
			volumes, voxels_sent, drains_sent, results_seen);
		if (errors == 0) $display("volume_gradient_magnitude_top_tb: clean");
		else $display("volume_gradient_magnitude_top_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
